// ===== src/wrlqt_pkg.sv =====
// ----------------------------------------------------------------------------
// wrlqt_pkg
// shared widths, reset values, register indexes and score constants for the
// rf link quality tracker
// ----------------------------------------------------------------------------
package wrlqt_pkg;

  localparam int TableDepthDefault = 128;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SNR_SMOOTHING    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SMOOTHING  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_WINDOW_US  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BSSID_MAX_AGE_US = 3'd3;

  localparam logic [1:0] KIND_MGMT  = 2'd0;
  localparam logic [1:0] KIND_CTRL  = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  localparam logic [15:0] SNR_SMOOTH_RST   = 16'd3277;
  localparam logic [15:0] NOISE_SMOOTH_RST = 16'd1311;
  localparam logic [31:0] RETRY_WIN_RST    = 32'd1000000;
  localparam logic [31:0] MAX_AGE_RST      = 32'd60000000;

  localparam logic signed [17:0] SNR_AVG_RST   = 18'sd6400;
  localparam logic signed [15:0] NOISE_AVG_RST = -16'sd24320;

  localparam int FULL_Q8    = 25600;
  localparam int W_CHAN     = 4000;
  localparam int W_SNR      = 3000;
  localparam int W_RETRY    = 2000;
  localparam int BSS_FULL   = 25600000;
  localparam int BSS_STEP   = 852480;
  // sum / 10000 as ((sum >> 4) * ceil(2^34 / 625)) >> 34
  localparam int SCORE_RECIP = 27487791;
  localparam int SCORE_SHIFT = 34;
  localparam int RETRY_BITS = 48;

  localparam logic [7:0] BSSID_BCAST_BYTE = 8'hFF;

endpackage

// ===== src/wifi_rf_link_quality_tracker_core.sv =====
// ----------------------------------------------------------------------------
// wifi_rf_link_quality_tracker_core
// per-frame link quality: snr/noise averages, windowed retry percentage,
// recently seen bssid table and a weighted link score
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | sink      | in_valid_i/in_stall_o | rssi, noise, kind, retry, bssid, time, cu
// out     | source    | out_valid_o/out_stall_i | snr, noise, retry pct, count, score
// cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// a frame with a valid bssid holds the sequencer until the table scan is done, so
// the one-entry-per-cycle table scan sets when the next frame can be accepted
// with the output free; the score is formed after the scan
// an ignored bssid skips the scan; a closing retry window adds the retry division
// after reset a clearing pass over all TABLE_DEPTH entries runs before the first frame
// the result sits in an output register, so a stalled output does not block
// the next frame until that frame itself is finished
// ----------------------------------------------------------------------------
module wifi_rf_link_quality_tracker_core #(
  parameter int TABLE_DEPTH = wrlqt_pkg::TableDepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [7:0]              rssi_dbm_i,
  input  logic signed [7:0]              noise_dbm_i,
  input  logic [1:0]                     frame_kind_i,
  input  logic                           retry_flag_i,
  input  logic [47:0]                    bssid_i,
  input  logic [62:0]                    time_us_i,
  input  logic [15:0]                    channel_use_q8_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [16:0]             avg_snr_q8_o,
  output logic signed [7:0]              avg_noise_dbm_o,
  output logic [14:0]                    retry_pct_q8_o,
  output logic [7:0]                     bssid_count_o,
  output logic [14:0]                    rf_score_q8_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wrlqt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import wrlqt_pkg::*;

  localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int CXW = (CW + 1 > 9) ? CW + 1 : 9;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_SNR_A = 4'd2;
  localparam logic [3:0] ST_SNR_B = 4'd3;
  localparam logic [3:0] ST_NSE_A = 4'd4;
  localparam logic [3:0] ST_NSE_B = 4'd5;
  localparam logic [3:0] ST_WIN   = 4'd6;
  localparam logic [3:0] ST_RLD   = 4'd7;
  localparam logic [3:0] ST_RDIV  = 4'd8;
  localparam logic [3:0] ST_WAIT  = 4'd9;
  localparam logic [3:0] ST_SC_A  = 4'd10;
  localparam logic [3:0] ST_SC_B  = 4'd11;
  localparam logic [3:0] ST_SC_C  = 4'd12;
  localparam logic [3:0] ST_SC_D  = 4'd13;
  localparam logic [3:0] ST_SDIV  = 4'd14;
  localparam logic [3:0] ST_FIN   = 4'd15;

  // configuration
  logic [15:0] snr_a_q, noise_a_q;
  logic [31:0] window_q, max_age_q;

  // sequencer and frame latch
  logic [3:0]  state_q;
  logic signed [7:0] rssi_q, noise_q;
  logic [1:0]  kind_q;
  logic        retry_q;
  logic [47:0] bssid_q;
  logic [62:0] now_q;
  logic [15:0] cu_q;

  // tracker state
  logic signed [17:0] snr_avg_q;
  logic signed [15:0] noise_avg_q;
  logic [14:0] retry_ratio_q;
  logic [31:0] frames_q, retries_q;
  logic [62:0] begin_q;
  logic [7:0]  pcount_q;

  // shared multiplier, accumulator and divider
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] mul_p;
  logic signed [57:0] acc_q;
  logic signed [57:0] acc_rnd;
  logic [31:0] rem_q, den_q, rem_n;
  logic [47:0] quo_q, quo_n;
  logic [32:0] div_sh;
  logic        div_ge;
  logic [5:0]  dcnt_q;
  logic [14:0] score_q;

  // output register
  logic        out_valid_q;
  logic signed [16:0] o_snr_q;
  logic signed [7:0]  o_noise_q;
  logic [14:0] o_retry_q, o_score_q;
  logic [7:0]  o_count_q;

  // table and scanner
  logic [47:0] addr_mem [TABLE_DEPTH];
  logic [62:0] time_mem [TABLE_DEPTH];
  logic [47:0] rd_addr_q;
  logic [62:0] rd_time_q;
  logic [IW-1:0] clr_q, issue_q, ridx_q;
  logic        scan_run_q, rvld_q, wr_pend_q, scan_done_q;
  logic        hit_q, hit_pred_q, pick_pred_q;
  logic [IW-1:0] hit_idx_q, pick_idx_q;
  logic [62:0] pick_time_q;
  logic [CW-1:0] count_q;
  logic        mem_we;
  logic [IW-1:0] mem_wa;
  logic [47:0] mem_wd_addr;
  logic [62:0] mem_wd_time;

  logic in_acc, bssid_ok;
  logic [63:0] age_diff;
  logic        rd_pred, rd_match;
  logic [CXW-1:0] cnt_adj;
  logic [7:0]  cnt_sat;

  logic        counted, win_close;
  logic [62:0] begin_n;
  logic [31:0] frames_n, retries_n;
  logic [63:0] el_diff;

  logic signed [8:0]  snr_diff;
  logic signed [20:0] sn5;
  logic signed [19:0] sn_half;
  logic [14:0] sn_term, cu_term, rt_term;
  logic signed [57:0] bs_term;
  logic [14:0] retry_clamped;
  logic signed [7:0] noise_out;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign bssid_ok    = (bssid_i[47:40] != BSSID_BCAST_BYTE) && (bssid_i != 48'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snr_a_q   <= SNR_SMOOTH_RST;
      noise_a_q <= NOISE_SMOOTH_RST;
      window_q  <= RETRY_WIN_RST;
      max_age_q <= MAX_AGE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SNR_SMOOTHING:    snr_a_q   <= cfg_data_i[15:0];
        CFG_NOISE_SMOOTHING:  noise_a_q <= cfg_data_i[15:0];
        CFG_RETRY_WINDOW_US:  window_q  <= cfg_data_i;
        CFG_BSSID_MAX_AGE_US: max_age_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // multiplier operand selection
  assign snr_diff = 9'(rssi_q) - 9'(noise_q);
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SNR_A: begin
        mul_a = 33'(snr_avg_q);
        mul_b = signed'({8'b0, 17'(17'h10000 - {1'b0, snr_a_q})});
      end
      ST_SNR_B: begin
        mul_a = 33'(signed'({snr_diff, 8'b0}));
        mul_b = signed'({9'b0, snr_a_q});
      end
      ST_NSE_A: begin
        mul_a = 33'(noise_avg_q);
        mul_b = signed'({8'b0, 17'(17'h10000 - {1'b0, noise_a_q})});
      end
      ST_NSE_B: begin
        mul_a = 33'(signed'({noise_q, 8'b0}));
        mul_b = signed'({9'b0, noise_a_q});
      end
      ST_WIN: begin
        mul_a = signed'({1'b0, retries_n});
        mul_b = 25'(FULL_Q8);
      end
      ST_SC_A: begin
        mul_a = signed'({25'b0, pcount_q});
        mul_b = 25'(BSS_STEP);
      end
      ST_SC_B: begin
        mul_a = signed'({18'b0, cu_term});
        mul_b = 25'(W_CHAN);
      end
      ST_SC_C: begin
        mul_a = signed'({18'b0, sn_term});
        mul_b = 25'(W_SNR);
      end
      ST_SC_D: begin
        mul_a = signed'({18'b0, rt_term});
        mul_b = 25'(W_RETRY);
      end
      ST_SDIV: begin
        mul_a = 33'(SCORE_RECIP);
        mul_b = signed'({1'b0, acc_q[27:4]});
      end
      default: ;
    endcase
  end
  assign mul_p   = mul_a * mul_b;
  assign acc_rnd = acc_q + 58'sd32768;

  // retry window
  assign counted  = (kind_q == KIND_MGMT) || (kind_q == KIND_DATA);
  assign begin_n  = (begin_q == 63'd0) ? now_q : begin_q;
  assign frames_n = (&frames_q) ? frames_q : frames_q + 32'd1;
  assign retries_n = (retry_q && !(&retries_q)) ? retries_q + 32'd1 : retries_q;
  assign el_diff  = {1'b0, now_q} - {1'b0, begin_n};
  assign win_close = el_diff[63] ? (window_q == 32'd0)
                                 : (el_diff[62:0] >= {31'b0, window_q});

  // divider step
  assign div_sh = {rem_q, quo_q[47]};
  assign div_ge = (div_sh >= {1'b0, den_q});
  assign rem_n  = div_ge ? 32'(div_sh - {1'b0, den_q}) : div_sh[31:0];
  assign quo_n  = {quo_q[46:0], div_ge};
  assign retry_clamped = (quo_n > 48'(FULL_Q8)) ? 15'(FULL_Q8) : quo_n[14:0];

  // score terms
  assign cu_term = ({16'b0, cu_q} > 32'(FULL_Q8)) ? 15'd0 : 15'(FULL_Q8 - 32'(cu_q));
  assign sn5     = (21'(snr_avg_q) <<< 2) + 21'(snr_avg_q);
  assign sn_half = 20'(sn5 >>> 1);
  assign sn_term = (snr_avg_q <= 18'sd0) ? 15'd0 :
                   (sn_half > 20'sd25600) ? 15'(FULL_Q8) : sn_half[14:0];
  assign rt_term = 15'(FULL_Q8) - retry_ratio_q;
  assign bs_term = (acc_q > 58'(BSS_FULL)) ? 58'sd0 : 58'(BSS_FULL) - acc_q;

  assign noise_out = 8'(noise_avg_q >>> 8) +
                     8'((noise_avg_q < 16'sd0) && (noise_avg_q[7:0] != 8'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      snr_avg_q   <= SNR_AVG_RST;
      noise_avg_q <= NOISE_AVG_RST;
      retry_ratio_q <= '0;
      frames_q    <= '0;
      retries_q   <= '0;
      begin_q     <= '0;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
      clr_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_FIN) out_valid_q <= 1'b0;
      case (state_q)
        ST_CLR: begin
          clr_q <= clr_q + IW'(1);
          if (clr_q == LAST_IDX) state_q <= ST_IDLE;
        end
        ST_IDLE: if (in_acc) state_q <= ST_SNR_A;
        ST_SNR_A: begin
          acc_q   <= mul_p;
          state_q <= ST_SNR_B;
        end
        ST_SNR_B: begin
          acc_q   <= acc_q + mul_p;
          state_q <= ST_NSE_A;
        end
        ST_NSE_A: begin
          snr_avg_q <= acc_rnd[33:16];
          acc_q     <= mul_p;
          state_q   <= ST_NSE_B;
        end
        ST_NSE_B: begin
          acc_q   <= acc_q + mul_p;
          state_q <= ST_WIN;
        end
        ST_WIN: begin
          noise_avg_q <= acc_rnd[31:16];
          state_q     <= ST_WAIT;
          if (counted) begin
            if (win_close) begin
              frames_q  <= '0;
              retries_q <= '0;
              begin_q   <= now_q;
              acc_q     <= mul_p;
              den_q     <= frames_n;
              state_q   <= ST_RLD;
            end else begin
              frames_q  <= frames_n;
              retries_q <= retries_n;
              begin_q   <= begin_n;
            end
          end
        end
        ST_RLD: begin
          quo_q   <= acc_q[47:0];
          rem_q   <= '0;
          dcnt_q  <= 6'(RETRY_BITS);
          state_q <= ST_RDIV;
        end
        ST_RDIV: begin
          quo_q  <= quo_n;
          rem_q  <= rem_n;
          dcnt_q <= dcnt_q - 6'd1;
          if (dcnt_q == 6'd1) begin
            retry_ratio_q <= retry_clamped;
            state_q       <= ST_WAIT;
          end
        end
        ST_WAIT: if (scan_done_q) state_q <= ST_SC_A;
        ST_SC_A: begin
          acc_q   <= mul_p;
          state_q <= ST_SC_B;
        end
        ST_SC_B: begin
          acc_q   <= bs_term + mul_p;
          state_q <= ST_SC_C;
        end
        ST_SC_C: begin
          acc_q   <= acc_q + mul_p;
          state_q <= ST_SC_D;
        end
        ST_SC_D: begin
          acc_q   <= acc_q + mul_p;
          state_q <= ST_SDIV;
        end
        ST_SDIV: begin
          score_q <= mul_p[SCORE_SHIFT+14:SCORE_SHIFT];
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            o_snr_q     <= snr_avg_q[16:0];
            o_noise_q   <= noise_out;
            o_retry_q   <= retry_ratio_q;
            o_count_q   <= pcount_q;
            o_score_q   <= score_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rssi_q  <= rssi_dbm_i;
      noise_q <= noise_dbm_i;
      kind_q  <= frame_kind_i;
      retry_q <= retry_flag_i;
      bssid_q <= bssid_i;
      now_q   <= time_us_i;
      cu_q    <= channel_use_q8_i;
    end
  end

  // table scan: one entry per cycle, registered read
  assign age_diff = {1'b0, now_q} - {1'b0, rd_time_q};
  assign rd_pred  = (rd_time_q != 63'd0) &&
                    (age_diff[63] ? (max_age_q != 32'd0)
                                  : (age_diff[62:0] < {31'b0, max_age_q}));
  assign rd_match = (rd_addr_q == bssid_q);
  assign cnt_adj  = CXW'(count_q) - CXW'(hit_q ? hit_pred_q : pick_pred_q) +
                    CXW'((max_age_q != 32'd0) && (now_q != 63'd0));
  assign cnt_sat  = (cnt_adj > CXW'(255)) ? 8'd255 : cnt_adj[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_run_q  <= 1'b0;
      rvld_q      <= 1'b0;
      wr_pend_q   <= 1'b0;
      scan_done_q <= 1'b0;
      pcount_q    <= '0;
      issue_q     <= '0;
    end else begin
      rvld_q    <= scan_run_q;
      wr_pend_q <= 1'b0;
      if (in_acc) begin
        scan_done_q <= !bssid_ok;
        scan_run_q  <= bssid_ok;
        issue_q     <= '0;
      end else if (scan_run_q) begin
        issue_q <= issue_q + IW'(1);
        if (issue_q == LAST_IDX) scan_run_q <= 1'b0;
      end
      if (rvld_q && ridx_q == LAST_IDX) wr_pend_q <= 1'b1;
      if (wr_pend_q) begin
        pcount_q    <= cnt_sat;
        scan_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= issue_q;
    if (in_acc) begin
      hit_q   <= 1'b0;
      count_q <= '0;
    end else if (rvld_q) begin
      count_q <= count_q + CW'(rd_pred);
      if (!hit_q) begin
        if (rd_match) begin
          hit_q      <= 1'b1;
          hit_idx_q  <= ridx_q;
          hit_pred_q <= rd_pred;
        end else if (ridx_q == '0 || rd_time_q < pick_time_q) begin
          pick_idx_q  <= ridx_q;
          pick_time_q <= rd_time_q;
          pick_pred_q <= rd_pred;
        end
      end
    end
  end

  always_comb begin
    mem_we      = 1'b0;
    mem_wa      = clr_q;
    mem_wd_addr = '0;
    mem_wd_time = '0;
    if (state_q == ST_CLR) begin
      mem_we = 1'b1;
    end else if (wr_pend_q) begin
      mem_we      = 1'b1;
      mem_wa      = hit_q ? hit_idx_q : pick_idx_q;
      mem_wd_addr = bssid_q;
      mem_wd_time = now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      addr_mem[mem_wa] <= mem_wd_addr;
      time_mem[mem_wa] <= mem_wd_time;
    end
    rd_addr_q <= addr_mem[issue_q];
    rd_time_q <= time_mem[issue_q];
  end

  assign out_valid_o     = out_valid_q;
  assign avg_snr_q8_o    = o_snr_q;
  assign avg_noise_dbm_o = o_noise_q;
  assign retry_pct_q8_o  = o_retry_q;
  assign bssid_count_o   = o_count_q;
  assign rf_score_q8_o   = o_score_q;

endmodule

// ===== src/wrlqt_checker.sv =====
// ----------------------------------------------------------------------------
// wrlqt_checker
// port-level checks for the rf link quality tracker
// ----------------------------------------------------------------------------
module wrlqt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [14:0] retry_pct_q8_o,
  input logic [14:0] rf_score_q8_o
);
  import wrlqt_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rf_score_q8_o))
    else $error("stalled result changed");

  // one transaction at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rf_score_q8_o <= 15'(FULL_Q8))
    else $error("score out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> retry_pct_q8_o <= 15'(FULL_Q8))
    else $error("retry percent out of range");

endmodule

bind wifi_rf_link_quality_tracker_core wrlqt_checker u_wrlqt_checker (.*);

// ===== verif/tb_wifi_rf_link_quality_tracker_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_wifi_rf_link_quality_tracker_core
// self-checking testbench: a queue-fed driver offers frame metadata, a
// built-in predictor of the averages, retry window, bssid table and score
// forms the expected result of each accepted frame, and a monitor compares
// every result transaction field by field under random gaps and stalls
// ----------------------------------------------------------------------------
module tb_wifi_rf_link_quality_tracker_core;
  import wrlqt_pkg::*;

  localparam int  Depth      = 128;
  localparam int  CycleLimit = 4000000;
  localparam longint Sat32   = 64'hFFFF_FFFF;

  typedef struct {
    logic signed [7:0] rssi;
    logic signed [7:0] noise;
    logic [1:0]        kind;
    logic              retry;
    logic [47:0]       bssid;
    logic [62:0]       now;
    logic [15:0]       chan_use;
  } frame_t;

  typedef struct {
    logic signed [16:0] snr;
    logic signed [7:0]  noise;
    logic [14:0]        retry_ratio;
    logic [7:0]         count;
    logic [14:0]        score;
  } link_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [7:0] rssi_dbm_i = '0;
  logic signed [7:0] noise_dbm_i = '0;
  logic [1:0] frame_kind_i = '0;
  logic retry_flag_i = 1'b0;
  logic [47:0] bssid_i = '0;
  logic [62:0] time_us_i = '0;
  logic [15:0] channel_use_q8_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [16:0] avg_snr_q8_o;
  logic signed [7:0] avg_noise_dbm_o;
  logic [14:0] retry_pct_q8_o;
  logic [7:0] bssid_count_o;
  logic [14:0] rf_score_q8_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  wifi_rf_link_quality_tracker_core DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  longint snr_smooth, noise_smooth, win_len, age_lim;
  longint snr_avg, noise_avg, retry_ratio, win_frames, win_retries, win_begin, present;
  logic [47:0] addr_tab [Depth];
  longint      seen_tab [Depth];

  frame_t       frame_q[$];
  link_result_t link_result_q[$];
  int  err_cnt = 0, frames_sent = 0, results_seen = 0, cycles = 0;
  bit  allow_gaps = 1'b1;
  bit  hold_req = 1'b0;
  int  hold_left = 0, in_gap = 0, out_gap = 0;
  longint cur_time;
  logic [47:0] bss_pool [200];

  function automatic longint smooth_q8(longint avg, longint sample, longint a);
    return (avg * (65536 - a) + sample * a + 32768) >>> 16;
  endfunction

  function automatic longint age_us(longint now, longint past);
    return now >= past ? now - past : 0;
  endfunction

  task automatic link_quality_predict(input frame_t f);
    link_result_t r;
    longint now, cu, sn, rt, bs, cnt;
    int pick;
    bit hit;
    now = longint'(f.now);
    snr_avg = smooth_q8(snr_avg, (longint'(f.rssi) - longint'(f.noise)) * 256, snr_smooth);
    noise_avg = smooth_q8(noise_avg, longint'(f.noise) * 256, noise_smooth);
    if (f.kind == KIND_MGMT || f.kind == KIND_DATA) begin
      if (win_begin == 0) win_begin = now;
      if (win_frames != Sat32) win_frames++;
      if (f.retry && win_retries != Sat32) win_retries++;
      if (age_us(now, win_begin) >= win_len) begin
        retry_ratio = win_retries * FULL_Q8 / win_frames;
        if (retry_ratio > FULL_Q8) retry_ratio = FULL_Q8;
        win_frames = 0;
        win_retries = 0;
        win_begin = now;
      end
    end
    if (f.bssid[47:40] != BSSID_BCAST_BYTE && f.bssid != 0) begin
      pick = 0;
      hit = 1'b0;
      for (int i = 0; i < Depth; i++) begin
        if (addr_tab[i] == f.bssid) begin
          seen_tab[i] = now;
          hit = 1'b1;
          break;
        end
        if (seen_tab[i] < seen_tab[pick]) pick = i;
      end
      if (!hit) begin
        addr_tab[pick] = f.bssid;
        seen_tab[pick] = now;
      end
      cnt = 0;
      for (int i = 0; i < Depth; i++)
        if (seen_tab[i] != 0 && age_us(now, seen_tab[i]) < age_lim) cnt++;
      present = cnt > 255 ? 255 : cnt;
    end
    cu = FULL_Q8 - longint'(f.chan_use);
    if (cu < 0) cu = 0;
    sn = 0;
    if (snr_avg > 0) begin
      sn = snr_avg * 5 / 2;
      if (sn > FULL_Q8) sn = FULL_Q8;
    end
    rt = FULL_Q8 - retry_ratio;
    if (rt < 0) rt = 0;
    bs = 2560000 - present * 85248;
    if (bs < 0) bs = 0;
    r.snr         = snr_avg[16:0];
    r.noise       = 8'(noise_avg / 256);
    r.retry_ratio = retry_ratio[14:0];
    r.count       = present[7:0];
    r.score       = 15'((4000 * cu + 3000 * sn + 2000 * rt + 10 * bs) / 10000);
    link_result_q.push_back(r);
  endtask

  // monitor and prediction at the rising edge
  always @(posedge clk_i) begin
    link_result_t e;
    frame_t f;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end else begin
      if (rst_ni && out_valid_o && !out_stall_i) begin
        results_seen++;
        if (link_result_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result transaction at cycle %0d", cycles);
        end else begin
          e = link_result_q.pop_front();
          if (e.snr !== avg_snr_q8_o || e.noise !== avg_noise_dbm_o ||
              e.retry_ratio !== retry_pct_q8_o || e.count !== bssid_count_o ||
              e.score !== rf_score_q8_o) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"mismatch #%0d: exp snr %0d noise %0d rtr %0d cnt %0d score %0d,",
                        " got %0d %0d %0d %0d %0d"},
                       results_seen, e.snr, e.noise, e.retry_ratio, e.count, e.score,
                       avg_snr_q8_o, avg_noise_dbm_o, retry_pct_q8_o, bssid_count_o,
                       rf_score_q8_o);
          end
        end
      end
      if (rst_ni && in_valid_i && !in_stall_o) begin
        f.rssi = rssi_dbm_i; f.noise = noise_dbm_i; f.kind = frame_kind_i;
        f.retry = retry_flag_i; f.bssid = bssid_i; f.now = time_us_i;
        f.chan_use = channel_use_q8_i;
        frames_sent++;
        link_quality_predict(f);
      end
    end
  end

  // driver
  bit in_taken;
  always @(posedge clk_i) in_taken = in_valid_i && !in_stall_o;

  always @(negedge clk_i) begin
    frame_t f;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (allow_gaps && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 2);
        in_valid_i <= 1'b0;
      end else if (frame_q.size() != 0) begin
        f = frame_q.pop_front();
        rssi_dbm_i <= f.rssi; noise_dbm_i <= f.noise; frame_kind_i <= f.kind;
        retry_flag_i <= f.retry; bssid_i <= f.bssid; time_us_i <= f.now;
        channel_use_q8_i <= f.chan_use;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stalls and the long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 1500;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else if (allow_gaps && $urandom_range(0, 4) == 0) begin
      out_gap = $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_SNR_SMOOTHING:    snr_smooth = longint'(val[15:0]);
      CFG_NOISE_SMOOTHING:  noise_smooth = longint'(val[15:0]);
      CFG_RETRY_WINDOW_US:  win_len = longint'(val);
      CFG_BSSID_MAX_AGE_US: age_lim = longint'(val);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_settings(input logic [15:0] s, input logic [15:0] n,
                                input logic [31:0] w, input logic [31:0] a);
    reg_write(CFG_SNR_SMOOTHING, 32'(s));
    reg_write(CFG_NOISE_SMOOTHING, 32'(n));
    reg_write(CFG_RETRY_WINDOW_US, w);
    reg_write(CFG_BSSID_MAX_AGE_US, a);
  endtask

  task automatic drain;
    wait (frame_q.size() == 0 && !in_valid_i && link_result_q.size() == 0);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic frame_t rand_frame(input int step_max);
    frame_t f;
    int sel;
    f.rssi = 8'($urandom); f.noise = 8'($urandom);
    f.kind = 2'($urandom); f.retry = 1'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 70)      f.bssid = bss_pool[$urandom_range(0, 199)];
    else if (sel < 90) f.bssid = 48'({$urandom, $urandom});
    else if (sel < 95) f.bssid = {BSSID_BCAST_BYTE, 40'($urandom)};
    else               f.bssid = '0;
    if ($urandom_range(0, 49) == 0) cur_time = cur_time - $urandom_range(1, 50);
    else cur_time = cur_time + $urandom_range(0, step_max);
    if (cur_time < 1) cur_time = 1;
    f.now = 63'(cur_time);
    f.chan_use = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 25600));
    return f;
  endfunction

  function automatic frame_t mk(input logic signed [7:0] r, input logic signed [7:0] n,
                                input logic [1:0] k, input logic rt, input logic [47:0] b,
                                input longint t, input logic [15:0] cu);
    frame_t f;
    f.rssi = r; f.noise = n; f.kind = k; f.retry = rt; f.bssid = b; f.now = 63'(t);
    f.chan_use = cu;
    return f;
  endfunction

  initial begin
    frame_t f;
    snr_smooth = longint'(SNR_SMOOTH_RST); noise_smooth = longint'(NOISE_SMOOTH_RST);
    win_len = longint'(RETRY_WIN_RST); age_lim = longint'(MAX_AGE_RST);
    snr_avg = longint'(SNR_AVG_RST); noise_avg = longint'(NOISE_AVG_RST);
    retry_ratio = 0; win_frames = 0; win_retries = 0; win_begin = 0; present = 0;
    for (int i = 0; i < Depth; i++) begin
      addr_tab[i] = '0;
      seen_tab[i] = 0;
    end
    for (int i = 0; i < 200; i++) begin
      bss_pool[i] = 48'({$urandom, $urandom});
      if (bss_pool[i][47:40] == BSSID_BCAST_BYTE || bss_pool[i] == 0)
        bss_pool[i][47:40] = 8'h02;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed frames under reset settings
    frame_q.push_back(mk(127, -128, KIND_MGMT, 1, bss_pool[0], 0, 0));
    frame_q.push_back(mk(-128, 127, KIND_DATA, 0, bss_pool[1], 5, 16'hFFFF));
    frame_q.push_back(mk(0, -95, KIND_CTRL, 1, 48'hFFFF_FFFF_FFFF, 10, 25600));
    frame_q.push_back(mk(-40, -90, KIND_OTHER, 1, 48'h0, 20, 25601));
    frame_q.push_back(mk(-50, -92, KIND_MGMT, 1, 48'hFF00_0000_0001, 30, 100));
    frame_q.push_back(mk(-60, -90, KIND_DATA, 1, bss_pool[0], 15, 12800));
    frame_q.push_back(mk(-20, -100, KIND_DATA, 0, 48'h7FFF_FFFF_FFFF, 1000040, 5000));
    frame_q.push_back(mk(127, 127, KIND_MGMT, 1, 48'h0000_0000_0001, 2000100, 0));
    frame_q.push_back(mk(-128, -128, KIND_DATA, 1, 48'hFEFF_FFFF_FFFF, 2000100, 65535));
    frame_q.push_back(mk(-30, -95, KIND_CTRL, 0, bss_pool[1], 3000200, 1));
    frame_q.push_back(mk(-35, -95, KIND_MGMT, 0, bss_pool[2], 3000200, 25599));
    frame_q.push_back(mk(-35, -95, KIND_DATA, 0, bss_pool[2], 62000000, 0));
    cur_time = 62000000;
    drain();

    // extreme settings, then zero window and zero age, then mid settings
    write_settings(16'd0, 16'hFFFF, 32'd1, 32'd1);
    repeat (150) frame_q.push_back(rand_frame(3));
    drain();
    write_settings(16'hFFFF, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (250) frame_q.push_back(rand_frame(100));
    hold_req = 1'b1;
    drain();
    write_settings(16'd1, 16'd1, 32'd0, 32'd0);
    repeat (100) frame_q.push_back(rand_frame(50));
    drain();
    for (int p = 0; p < 5; p++) begin
      write_settings(16'($urandom), 16'($urandom), $urandom_range(100, 3000),
                     $urandom_range(500, 30000));
      repeat (250) frame_q.push_back(rand_frame(200));
      drain();
    end

    // final stretch without gaps or stalls, ending at the largest timestamp
    allow_gaps = 1'b0;
    write_settings(SNR_SMOOTH_RST, NOISE_SMOOTH_RST, 32'd5000, 32'd40000);
    repeat (150) frame_q.push_back(rand_frame(300));
    f = rand_frame(1);
    f.now = 63'h7FFF_FFFF_FFFF_FFFF;
    frame_q.push_back(f);
    drain();

    $display("covered %0d frames, %0d results, over 10 register settings incl. extremes",
             frames_sent, results_seen);
    $display("with random gaps, stalls and one long receiver hold-off; mismatches: %0d",
             err_cnt);
    if (err_cnt == 0 && link_result_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/wrlqt_pkg.sv
src/wifi_rf_link_quality_tracker_core.sv
src/wrlqt_checker.sv
verif/tb_wifi_rf_link_quality_tracker_core.sv
